@@ sv/lop_pkg.sv @@
package lop_pkg;

    localparam int OUT_PAGE_W = 48;
    localparam int OCC_W      = 7;

    localparam logic [1:0] OP_SEARCH      = 2'd0;
    localparam logic [1:0] OP_APPEND      = 2'd1;
    localparam logic [1:0] OP_EVICT_OLD   = 2'd2;
    localparam logic [1:0] OP_EVICT_NAMED = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_DUP       = 2'd3;

    typedef struct packed {
        logic [1:0]            opcode;
        logic [OUT_PAGE_W-1:0] page_number;
        logic                  ref_bit_in;
        logic                  filter_bit_in;
        logic                  dirty_in;
    } req_t;

    typedef struct packed {
        logic [1:0]            status;
        logic [OUT_PAGE_W-1:0] page_out;
        logic                  ref_bit_out;
        logic                  filter_bit_out;
        logic                  dirty_out;
        logic [OCC_W-1:0]      occupancy;
    } rsp_t;

    typedef struct packed {
        logic clear;
        logic sample;
    } scan_ctl_t;

endpackage

@@ sv/lop_ram.sv @@
module lop_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

@@ sv/lop_scan.sv @@
module lop_scan #(
    parameter int KW = 48,
    parameter int IW = 6
) (
    input  logic               clk,
    input  logic               rst_n,
    input  lop_pkg::scan_ctl_t ctl,
    input  logic [KW-1:0]      probe,
    input  logic               rd_valid,
    input  logic [KW-1:0]      rd_key,
    input  logic [2:0]         rd_bits,
    input  logic [IW-1:0]      rd_idx,
    output logic               hit,
    output logic [IW-1:0]      hit_idx,
    output logic [2:0]         hit_bits,
    output logic               free_found,
    output logic [IW-1:0]      free_idx
);

    import lop_pkg::*;

    logic          hit_reg;
    logic          free_reg;
    logic [IW-1:0] hit_idx_reg;
    logic [2:0]    hit_bits_reg;
    logic [IW-1:0] free_idx_reg;
    logic          match;

    assign match = rd_valid && (rd_key == probe);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
        end
        else if (ctl.clear)
        begin
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
        end
        else if (ctl.sample)
        begin
            if (match)
            begin
                hit_reg <= 1'b1;
            end
            if (!rd_valid)
            begin
                free_reg <= 1'b1;
            end
        end
    end

    // first hit and first free slot win
    always_ff @(posedge clk)
    begin
        if (ctl.sample && match && !hit_reg)
        begin
            hit_idx_reg  <= rd_idx;
            hit_bits_reg <= rd_bits;
        end
        if (ctl.sample && !rd_valid && !free_reg)
        begin
            free_idx_reg <= rd_idx;
        end
    end

    assign hit        = hit_reg;
    assign hit_idx    = hit_idx_reg;
    assign hit_bits   = hit_bits_reg;
    assign free_found = free_reg;
    assign free_idx   = free_idx_reg;

endmodule

@@ sv/lru_ordered_page_list.sv @@
// channel | dir | payload       | handshake
// req     | in  | lop_pkg::req_t | req_valid / req_ready
// rsp     | out | lop_pkg::rsp_t | rsp_valid / rsp_ready
//
// Search, append and named eviction sweep the slot store one entry a cycle
// through a single key comparator. A scanning beat passes S_SCAN, S_SCAN_END
// and S_DECIDE; an append then writes in S_APP1 and S_APP2, while a named
// eviction hit and evict-oldest pass S_RD, S_CAP and S_UNLINK. Evict-oldest
// when empty goes straight to S_DONE. After reset a clearing pass zeroes the
// valid marks; req_ready stays low during it. A finished beat stalls in
// S_DONE while the output register holds an untaken result.
module lru_ordered_page_list #(
    parameter int CAPACITY  = 64,
    parameter int PAGE_BITS = 48
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  lop_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output lop_pkg::rsp_t rsp
);

    import lop_pkg::*;

    localparam int KW = PAGE_BITS;
    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = KW + 4;
    localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_SCAN     = 4'd2;
    localparam logic [3:0] S_SCAN_END = 4'd3;
    localparam logic [3:0] S_DECIDE   = 4'd4;
    localparam logic [3:0] S_APP1     = 4'd5;
    localparam logic [3:0] S_APP2     = 4'd6;
    localparam logic [3:0] S_RD       = 4'd7;
    localparam logic [3:0] S_CAP      = 4'd8;
    localparam logic [3:0] S_UNLINK   = 4'd9;
    localparam logic [3:0] S_DONE     = 4'd10;

    logic [3:0]    state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [IW-1:0] data_idx_reg, data_idx_next;
    logic          pend_reg, pend_next;
    req_t          req_reg, req_next;
    logic [IW-1:0] target_reg, target_next;
    logic [IW-1:0] oldest_reg, oldest_next;
    logic [IW-1:0] newest_reg, newest_next;
    logic [CW-1:0] count_reg, count_next;
    rsp_t          res_reg, res_next;
    logic [IW-1:0] p_reg, p_next;
    logic [IW-1:0] n_reg, n_next;
    logic          out_valid_reg, out_valid_next;
    rsp_t          out_reg, out_next;

    logic          ent_we;
    logic [IW-1:0] ent_waddr, ent_raddr;
    logic [EW-1:0] ent_wdata, ent_rdata;
    logic          nxt_we;
    logic [IW-1:0] nxt_waddr, nxt_wdata, nxt_rdata;
    logic          prv_we;
    logic [IW-1:0] prv_waddr, prv_wdata, prv_rdata;

    scan_ctl_t     scan_ctl;
    logic          hit;
    logic [IW-1:0] hit_idx;
    logic [2:0]    hit_bits;
    logic          free_found;
    logic [IW-1:0] free_idx;

    logic [OUT_PAGE_W+63:0] key_wide;
    logic [KW-1:0]          probe;
    logic [KW+OUT_PAGE_W-1:0] probe_ext;
    logic [KW+OUT_PAGE_W-1:0] stored_ext;
    logic [CW+OCC_W-1:0]    occ_ext;

    assign key_wide   = {64'd0, req_reg.page_number};
    assign probe      = key_wide[KW-1:0];
    assign probe_ext  = {{OUT_PAGE_W{1'b0}}, probe};
    assign stored_ext = {{OUT_PAGE_W{1'b0}}, ent_rdata[KW-1:0]};
    assign occ_ext    = {{OCC_W{1'b0}}, count_reg};

    lop_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_entries (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    lop_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_next_links (
        .clk   (clk),
        .we    (nxt_we),
        .waddr (nxt_waddr),
        .wdata (nxt_wdata),
        .raddr (target_reg),
        .rdata (nxt_rdata)
    );

    lop_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_prev_links (
        .clk   (clk),
        .we    (prv_we),
        .waddr (prv_waddr),
        .wdata (prv_wdata),
        .raddr (target_reg),
        .rdata (prv_rdata)
    );

    lop_scan #(.KW(KW), .IW(IW)) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (scan_ctl),
        .probe      (probe),
        .rd_valid   (ent_rdata[KW+3]),
        .rd_key     (ent_rdata[KW-1:0]),
        .rd_bits    (ent_rdata[KW+2:KW]),
        .rd_idx     (data_idx_reg),
        .hit        (hit),
        .hit_idx    (hit_idx),
        .hit_bits   (hit_bits),
        .free_found (free_found),
        .free_idx   (free_idx)
    );

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        data_idx_next  = data_idx_reg;
        pend_next      = (state_reg == S_SCAN);
        req_next       = req_reg;
        target_next    = target_reg;
        oldest_next    = oldest_reg;
        newest_next    = newest_reg;
        count_next     = count_reg;
        res_next       = res_reg;
        p_next         = p_reg;
        n_next         = n_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        out_next       = out_reg;

        ent_we    = 1'b0;
        ent_waddr = target_reg;
        ent_wdata = '0;
        ent_raddr = target_reg;
        nxt_we    = 1'b0;
        nxt_waddr = target_reg;
        nxt_wdata = target_reg;
        prv_we    = 1'b0;
        prv_waddr = target_reg;
        prv_wdata = target_reg;

        scan_ctl.clear  = (state_reg == S_IDLE);
        scan_ctl.sample = pend_reg && ((state_reg == S_SCAN) || (state_reg == S_SCAN_END));

        case (state_reg)
            S_CLEAR:
            begin
                ent_we    = 1'b1;
                ent_waddr = idx_reg;
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next = req;
                    res_next = '0;
                    if (req.opcode == OP_EVICT_OLD)
                    begin
                        if (count_reg == '0)
                        begin
                            res_next.status = ST_NOT_FOUND;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            target_next = oldest_reg;
                            state_next  = S_RD;
                        end
                    end
                    else
                    begin
                        idx_next   = '0;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                ent_raddr     = idx_reg;
                data_idx_next = idx_reg;
                if (idx_reg == LAST_IDX)
                begin
                    state_next = S_SCAN_END;
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            S_SCAN_END:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                case (req_reg.opcode)
                    OP_SEARCH:
                    begin
                        if (hit)
                        begin
                            res_next.page_out       = probe_ext[OUT_PAGE_W-1:0];
                            res_next.ref_bit_out    = hit_bits[0];
                            res_next.filter_bit_out = hit_bits[1];
                            res_next.dirty_out      = hit_bits[2];
                        end
                        else
                        begin
                            res_next.status = ST_NOT_FOUND;
                        end
                        state_next = S_DONE;
                    end
                    OP_APPEND:
                    begin
                        if (hit)
                        begin
                            res_next.status = ST_DUP;
                            state_next      = S_DONE;
                        end
                        else if ((count_reg == FULL_CNT) || !free_found)
                        begin
                            res_next.status = ST_FULL;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            target_next = free_idx;
                            state_next  = S_APP1;
                        end
                    end
                    default:
                    begin
                        if (hit)
                        begin
                            res_next.page_out       = probe_ext[OUT_PAGE_W-1:0];
                            res_next.ref_bit_out    = hit_bits[0];
                            res_next.filter_bit_out = hit_bits[1];
                            res_next.dirty_out      = hit_bits[2];
                            target_next             = hit_idx;
                            state_next              = S_RD;
                        end
                        else
                        begin
                            res_next.status = ST_NOT_FOUND;
                            state_next      = S_DONE;
                        end
                    end
                endcase
            end
            S_APP1:
            begin
                ent_we    = 1'b1;
                ent_wdata = {1'b1, req_reg.dirty_in, req_reg.filter_bit_in,
                             req_reg.ref_bit_in, probe};
                nxt_we    = 1'b1;
                prv_we    = 1'b1;
                if (count_reg == '0)
                begin
                    oldest_next = target_reg;
                end
                else
                begin
                    prv_wdata = newest_reg;
                end
                state_next = S_APP2;
            end
            S_APP2:
            begin
                if (count_reg != '0)
                begin
                    nxt_we    = 1'b1;
                    nxt_waddr = newest_reg;
                end
                newest_next = target_reg;
                count_next  = count_reg + CW'(1);
                state_next  = S_DONE;
            end
            S_RD:
            begin
                state_next = S_CAP;
            end
            S_CAP:
            begin
                p_next = prv_rdata;
                n_next = nxt_rdata;
                if (req_reg.opcode == OP_EVICT_OLD)
                begin
                    res_next.page_out       = stored_ext[OUT_PAGE_W-1:0];
                    res_next.ref_bit_out    = ent_rdata[KW];
                    res_next.filter_bit_out = ent_rdata[KW+1];
                    res_next.dirty_out      = ent_rdata[KW+2];
                end
                state_next = S_UNLINK;
            end
            S_UNLINK:
            begin
                if (target_reg == oldest_reg)
                begin
                    oldest_next = n_reg;
                end
                else
                begin
                    nxt_we    = 1'b1;
                    nxt_waddr = p_reg;
                    nxt_wdata = n_reg;
                end
                if (target_reg == newest_reg)
                begin
                    newest_next = p_reg;
                end
                else
                begin
                    prv_we    = 1'b1;
                    prv_waddr = n_reg;
                    prv_wdata = p_reg;
                end
                ent_we = 1'b1;
                if (count_reg != '0)
                begin
                    count_next = count_reg - CW'(1);
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    out_next           = res_reg;
                    out_next.occupancy = occ_ext[OCC_W-1:0];
                    out_valid_next     = 1'b1;
                    state_next         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            oldest_reg    <= '0;
            newest_reg    <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            oldest_reg    <= oldest_next;
            newest_reg    <= newest_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_idx_reg <= data_idx_next;
        req_reg      <= req_next;
        target_reg   <= target_next;
        res_reg      <= res_next;
        p_reg        <= p_next;
        n_reg        <= n_next;
        out_reg      <= out_next;
    end

endmodule
